// ----- hdl/glw_pkg.sv -----
// Shared types, constants and helpers for the greedy line wrapper.
// No dependencies; every module of the block imports this package.
`default_nettype none
package glw_pkg;

   localparam int unsigned POS_W  = 16;
   localparam int unsigned COLS_W = 11;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned LW_W   = 10;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [COLS_W-1:0] cols_type;
   typedef logic [CP_W-1:0]   cp_type;
   typedef logic [LW_W-1:0]   lw_type;

   localparam pos_type  MAX_POSITION = 16'hFFFF;
   localparam cols_type COLS_MAX     = 11'd2047;
   localparam lw_type   LINE_WIDTH_RESET = 10'd80;

   // Character codes
   localparam cp_type CP_NUL     = 21'h00;
   localparam cp_type CP_MARKER  = 21'h19;
   localparam cp_type CP_NEWLINE = 21'h0A;
   localparam cp_type CP_SPACE   = 21'h20;
   localparam cp_type CP_U       = 21'h75;
   localparam cp_type CP_A       = 21'h61;
   localparam cp_type CP_I       = 21'h69;
   localparam cp_type CP_B       = 21'h62;
   localparam cp_type CP_O       = 21'h6F;
   localparam cp_type CP_BRACE   = 21'h7D;

   // Register map: index is csr_paddr[2]
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic REG_LINE_WIDTH = 1'b0;

   typedef struct packed {
      pos_type  line_start;
      pos_type  line_end;
      logic     text_done;
      logic     run_last;
   } span_type;

   typedef struct packed {
      pos_type  char_position;
      pos_type  line_begin;
      pos_type  space_position;
      logic     space_seen;
      cols_type cols_before_space;
      cols_type line_columns;
      logic     in_marker;
      logic     text_stopped;
   } text_state_type;

   localparam text_state_type TEXT_CLEAR = '0;

   typedef struct packed {
      logic [1:0] count;
      span_type   first;
      span_type   second;
   } step_out_type;

   function automatic pos_type pos_inc(input pos_type p);
      return (p == MAX_POSITION) ? p : p + 16'd1;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/greedy_line_wrapper.sv -----
// Greedy line wrapper top level: input word register, wrap step, span queue.
// A character word is taken into the input word register, and its spans are then written
// to the span queue, from which the first can leave; a second span of the same word follows.
// Throughput: one character per cycle; the input stalls while the span queue
// holds more than two spans, so a character that ends two lines always fits.
// Reset: synchronous; clears text state, queue and sets line_width to 80.
// Depends on glw_pkg, glw_step and glw_span_fifo.
`default_nettype none
module greedy_line_wrapper (
   input  var logic                                   clock,
   input  var logic                                   reset,
   // character words
   input  var logic                                   req_valid,
   output logic                                       req_stall,
   input  var glw_pkg::cp_type                        req_code_point,
   input  var logic [1:0]                             req_char_cols,
   input  var logic                                   req_last_char,
   // line spans
   output logic                                       rsp_valid,
   input  var logic                                   rsp_stall,
   output glw_pkg::pos_type                           rsp_line_start,
   output glw_pkg::pos_type                           rsp_line_end,
   output logic                                       rsp_text_done,
   output logic                                       rsp_run_last,
   // configuration
   input  var logic                                   csr_psel,
   input  var logic                                   csr_penable,
   input  var logic                                   csr_pwrite,
   input  var logic [glw_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  var logic [glw_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [glw_pkg::CSR_DATA_W-1:0]             csr_prdata,
   output logic                                       csr_pready
);
   import glw_pkg::*;

   lw_type         line_width_ff, line_width_in;
   logic           item_valid_ff, item_valid_in;
   cp_type         code_ff, code_in;
   logic [1:0]     cols_ff, cols_in;
   logic           last_ff, last_in;
   text_state_type text_ff, text_in;
   text_state_type text_next;
   step_out_type   step_res;
   span_type       head;
   logic           not_empty;
   logic           room_two;
   logic           pop;
   logic           process;
   logic           load;
   logic           csr_write;

   // ---- configuration ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      line_width_in = line_width_ff;
      if (csr_write && csr_paddr[2] == REG_LINE_WIDTH) begin
         line_width_in = csr_pwdata[LW_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_LINE_WIDTH: csr_prdata = {{(CSR_DATA_W-LW_W){1'b0}}, line_width_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ---- input word register ----
   assign process   = item_valid_ff && room_two;
   assign req_stall = item_valid_ff && !room_two;
   assign load      = req_valid && !req_stall;

   always_comb begin
      item_valid_in = load ? 1'b1 : (process ? 1'b0 : item_valid_ff);
      code_in       = load ? req_code_point : code_ff;
      cols_in       = load ? req_char_cols  : cols_ff;
      last_in       = load ? req_last_char  : last_ff;
      text_in       = process ? text_next : text_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         item_valid_ff <= 1'b0;
         text_ff       <= TEXT_CLEAR;
      end else begin
         line_width_ff <= line_width_in;
         item_valid_ff <= item_valid_in;
         text_ff       <= text_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      cols_ff <= cols_in;
      last_ff <= last_in;
   end

   glw_step u_step (
      .st         (text_ff),
      .code_point (code_ff),
      .char_cols  (cols_ff),
      .last_char  (last_ff),
      .line_width (line_width_ff),
      .st_next    (text_next),
      .res        (step_res)
   );

   // ---- span queue ----
   assign pop = not_empty && !rsp_stall;

   glw_span_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (process ? step_res.count : 2'd0),
      .push_first  (step_res.first),
      .push_second (step_res.second),
      .pop         (pop),
      .head        (head),
      .not_empty   (not_empty),
      .room_two    (room_two)
   );

   assign rsp_valid      = not_empty;
   assign rsp_line_start = head.line_start;
   assign rsp_line_end   = head.line_end;
   assign rsp_text_done  = head.text_done;
   assign rsp_run_last   = head.run_last;

endmodule
`default_nettype wire

// ----- hdl/glw_step.sv -----
// Per-character wrap decision: next text state and up to two line spans.
// Purely combinational; depends on glw_pkg.
`default_nettype none
module glw_step (
   input  var glw_pkg::text_state_type st,
   input  var glw_pkg::cp_type         code_point,
   input  var logic [1:0]              char_cols,
   input  var logic                    last_char,
   input  var glw_pkg::lw_type         line_width,
   output glw_pkg::text_state_type     st_next,
   output glw_pkg::step_out_type       res
);
   import glw_pkg::*;

   always_comb begin
      text_state_type s;
      step_out_type   r;
      logic [11:0]    sum;
      logic [11:0]    drop;
      logic [11:0]    grown;
      logic           term;
      logic           emit_final;

      s          = st;
      r          = '0;
      emit_final = 1'b0;
      sum        = {1'b0, st.line_columns} + {10'b0, char_cols};
      drop       = {1'b0, st.cols_before_space} + 12'd1;
      grown      = '0;
      term       = (code_point == CP_U) || (code_point == CP_A) ||
                   (code_point == CP_I) || (code_point == CP_B) ||
                   (code_point == CP_O) || (code_point == CP_BRACE);

      if (st.text_stopped) begin
         // drop everything until the end of the text
         if (last_char) begin
            s = TEXT_CLEAR;
         end
      end else if (st.in_marker || code_point == CP_MARKER) begin
         s.in_marker     = !(st.in_marker && term);
         s.char_position = pos_inc(st.char_position);
         emit_final      = 1'b1;
      end else if (code_point == CP_NUL) begin
         r.count = 2'd1;
         r.first = '{line_start: st.line_begin, line_end: st.char_position,
                     text_done: 1'b1, run_last: 1'b0};
         if (last_char) begin
            s = TEXT_CLEAR;
         end else begin
            s.text_stopped = 1'b1;
         end
      end else if (code_point == CP_NEWLINE) begin
         s.char_position = pos_inc(st.char_position);
         r.count         = 2'd1;
         r.first = '{line_start: st.line_begin, line_end: s.char_position,
                     text_done: 1'b0, run_last: 1'b0};
         s.line_begin    = s.char_position;
         s.space_seen    = 1'b0;
         s.line_columns  = '0;
         emit_final      = 1'b1;
      end else begin
         if (sum > {2'b0, line_width}) begin
            r.count = 2'd1;
            if (st.space_seen) begin
               // cut at the last space; the space joins neither line
               r.first = '{line_start: st.line_begin, line_end: st.space_position,
                           text_done: 1'b0, run_last: 1'b0};
               s.line_begin   = pos_inc(st.space_position);
               s.space_seen   = 1'b0;
               s.line_columns = ({1'b0, st.line_columns} > drop) ?
                                st.line_columns - drop[COLS_W-1:0] : '0;
            end else begin
               r.first = '{line_start: st.line_begin, line_end: st.char_position,
                           text_done: 1'b0, run_last: 1'b0};
               s.line_begin   = st.char_position;
               s.line_columns = '0;
            end
         end
         if (code_point == CP_SPACE) begin
            s.space_position    = st.char_position;
            s.cols_before_space = s.line_columns;
            s.space_seen        = 1'b1;
         end
         grown = {1'b0, s.line_columns} + {10'b0, char_cols};
         s.line_columns  = (grown > {1'b0, COLS_MAX}) ? COLS_MAX : grown[COLS_W-1:0];
         s.char_position = pos_inc(st.char_position);
         emit_final      = 1'b1;
      end

      if (emit_final && last_char) begin
         if (r.count == 2'd0) begin
            r.first = '{line_start: s.line_begin, line_end: s.char_position,
                        text_done: 1'b1, run_last: 1'b0};
         end else begin
            r.second = '{line_start: s.line_begin, line_end: s.char_position,
                         text_done: 1'b1, run_last: 1'b0};
         end
         r.count = r.count + 2'd1;
         s       = TEXT_CLEAR;
      end

      // mark the last span of this character
      if (r.count == 2'd1) begin
         r.first.run_last = 1'b1;
      end else if (r.count == 2'd2) begin
         r.second.run_last = 1'b1;
      end

      st_next = s;
      res     = r;
   end

endmodule
`default_nettype wire

// ----- hdl/glw_span_fifo.sv -----
// Four-entry span queue that takes up to two spans per cycle and gives one.
// Depends on glw_pkg.
`default_nettype none
module glw_span_fifo (
   input  var logic               clock,
   input  var logic               reset,
   input  var logic [1:0]         push_count,
   input  var glw_pkg::span_type  push_first,
   input  var glw_pkg::span_type  push_second,
   input  var logic               pop,
   output glw_pkg::span_type      head,
   output logic                   not_empty,
   output logic                   room_two
);
   import glw_pkg::*;

   span_type   entry_ff [4];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] wr_next;

   assign wr_next   = wr_ptr_ff + 2'd1;
   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 3'd0);
   assign room_two  = (count_ff <= 3'd2);

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + push_count;
      count_in  = count_ff + {1'b0, push_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push_second;
      end
   end

endmodule
`default_nettype wire

// ----- bench/tb_greedy_line_wrapper.sv -----
// Self-checking bench for greedy_line_wrapper: character words in, line spans out.
// Depends on glw_pkg and the greedy_line_wrapper RTL; it predicts every span on
// its own and compares each one as it leaves the block.
module tb_greedy_line_wrapper;
   import glw_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_REPORTS   = 40;
   localparam logic [CSR_ADDR_W-1:0] LINE_WIDTH_ADDR = {REG_LINE_WIDTH, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   cp_type                req_code_point = '0;
   logic [1:0]            req_char_cols = '0;
   logic                  req_last_char = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   pos_type               rsp_line_start;
   pos_type               rsp_line_end;
   logic                  rsp_text_done;
   logic                  rsp_run_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // wrap state as the block should hold it
   int      wrap_width = int'(LINE_WIDTH_RESET);
   pos_type wrap_pos = '0;
   pos_type wrap_line_begin = '0;
   pos_type wrap_space_pos = '0;
   logic    wrap_space_seen = 1'b0;
   int      wrap_cols_before_space = 0;
   int      wrap_line_cols = 0;
   logic    wrap_in_marker = 1'b0;
   logic    wrap_stopped = 1'b0;

   span_type expected_spans[$];
   int       live_items = 0;
   int       error_count = 0;
   int       cycle_count = 0;
   int       send_idle_pct = 16;
   int       recv_idle_pct = 84;
   int       hold_request = 0;
   int       hold_left = 0;

   greedy_line_wrapper dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .req_char_cols  (req_char_cols),
      .req_last_char  (req_last_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_line_start (rsp_line_start),
      .rsp_line_end   (rsp_line_end),
      .rsp_text_done  (rsp_text_done),
      .rsp_run_last   (rsp_run_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                  want);
   endtask

   function automatic cp_type letter(input byte c);
      return cp_type'(c);
   endfunction

   function automatic pos_type bump_pos(input pos_type p);
      return (p == MAX_POSITION) ? p : pos_type'(p + 1'b1);
   endfunction

   function automatic span_type span_of(input pos_type s, input pos_type e, input logic done);
      span_type sp;
      sp.line_start = s;
      sp.line_end   = e;
      sp.text_done  = done;
      sp.run_last   = 1'b0;
      return sp;
   endfunction

   function automatic void clear_wrap_state();
      wrap_pos = '0;
      wrap_line_begin = '0;
      wrap_space_pos = '0;
      wrap_space_seen = 1'b0;
      wrap_cols_before_space = 0;
      wrap_line_cols = 0;
      wrap_in_marker = 1'b0;
      wrap_stopped = 1'b0;
   endfunction

   // Advance the wrap state by one character word and queue the spans it ends.
   task automatic wrap_char(input cp_type cp, input logic [1:0] cols, input logic last);
      int   n;
      int   drop;
      logic nul_end;
      n = 0;
      nul_end = 1'b0;
      if (wrap_stopped) begin
         if (last)
            clear_wrap_state();
      end else begin
         live_items++;
         if (wrap_in_marker || cp == CP_MARKER) begin
            wrap_in_marker = !(wrap_in_marker &&
                               (cp inside {CP_U, CP_A, CP_I, CP_B, CP_O, CP_BRACE}));
            wrap_pos = bump_pos(wrap_pos);
         end else if (cp == CP_NUL) begin
            expected_spans.push_back(span_of(wrap_line_begin, wrap_pos, 1'b1));
            n++;
            nul_end = 1'b1;
            if (last)
               clear_wrap_state();
            else
               wrap_stopped = 1'b1;
         end else if (cp == CP_NEWLINE) begin
            wrap_pos = bump_pos(wrap_pos);
            expected_spans.push_back(span_of(wrap_line_begin, wrap_pos, 1'b0));
            n++;
            wrap_line_begin = wrap_pos;
            wrap_space_seen = 1'b0;
            wrap_line_cols = 0;
         end else begin
            if (wrap_line_cols + int'(cols) > wrap_width) begin
               if (wrap_space_seen) begin
                  // cut at the last space; the space belongs to neither line
                  drop = wrap_cols_before_space + 1;
                  expected_spans.push_back(span_of(wrap_line_begin, wrap_space_pos, 1'b0));
                  n++;
                  wrap_line_begin = bump_pos(wrap_space_pos);
                  wrap_space_seen = 1'b0;
                  wrap_line_cols = (wrap_line_cols > drop) ? wrap_line_cols - drop : 0;
               end else begin
                  expected_spans.push_back(span_of(wrap_line_begin, wrap_pos, 1'b0));
                  n++;
                  wrap_line_begin = wrap_pos;
                  wrap_line_cols = 0;
               end
            end
            if (cp == CP_SPACE) begin
               wrap_space_pos = wrap_pos;
               wrap_cols_before_space = wrap_line_cols;
               wrap_space_seen = 1'b1;
            end
            wrap_line_cols = wrap_line_cols + int'(cols);
            if (wrap_line_cols > int'(COLS_MAX))
               wrap_line_cols = int'(COLS_MAX);
            wrap_pos = bump_pos(wrap_pos);
         end
         if (last && !nul_end) begin
            expected_spans.push_back(span_of(wrap_line_begin, wrap_pos, 1'b1));
            n++;
            clear_wrap_state();
         end
         if (n > 0)
            expected_spans[expected_spans.size() - 1].run_last = 1'b1;
      end
   endtask

   // Offer one character word, hold it until accepted, then predict.
   task automatic send_char(input cp_type cp, input logic [1:0] cols, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_code_point <= cp;
      req_char_cols  <= cols;
      req_last_char  <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      wrap_char(cp, cols, last);
   endtask

   // Drop valid and wait until every predicted span has come out, plus settle time.
   task automatic drain_spans();
      req_valid <= 1'b0;
      while (expected_spans.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_line_width(input lw_type want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= LINE_WIDTH_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata[LW_W-1:0] !== want)
         report_mismatch("line_width readback", int'(csr_prdata[LW_W-1:0]), int'(want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_line_width(input logic [CSR_DATA_W-1:0] word);
      drain_spans();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LINE_WIDTH_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      wrap_width = int'(word[LW_W-1:0]);
      @(posedge clock);
      check_line_width(word[LW_W-1:0]);
   endtask

   // One well-formed text: words, spaces, wide and zero-width characters,
   // newlines, markers and the odd early NUL, last flag on the final word.
   task automatic send_random_text();
      int         len;
      int         i;
      int         r;
      int         marker_left;
      cp_type     cp;
      logic [1:0] cols;
      len = ($urandom_range(9) == 0) ? int'($urandom_range(400, 60))
                                     : int'($urandom_range(60, 1));
      marker_left = 0;
      for (i = 0; i < len; i++) begin
         r = $urandom_range(99);
         cols = 2'd1;
         if (marker_left > 1) begin
            case ($urandom_range(5))
               0: cp = CP_NEWLINE;
               1: cp = CP_SPACE;
               2: cp = CP_NUL;
               default: cp = cp_type'($urandom_range(8'h39, 8'h30));
            endcase
            cols = 2'($urandom_range(3));
            marker_left--;
         end else if (marker_left == 1) begin
            case ($urandom_range(5))
               0: cp = CP_U;
               1: cp = CP_A;
               2: cp = CP_I;
               3: cp = CP_B;
               4: cp = CP_O;
               default: cp = CP_BRACE;
            endcase
            marker_left = 0;
         end else if (r < 55) begin
            cp = cp_type'($urandom_range(8'h7E, 8'h21));
         end else if (r < 70) begin
            cp = CP_SPACE;
         end else if (r < 75) begin
            cp = CP_NEWLINE;
            cols = 2'($urandom_range(3));
         end else if (r < 84) begin
            cp = cp_type'($urandom_range(21'h9FFF, 21'h4E00));
            cols = 2'd2;
         end else if (r < 89) begin
            cp = cp_type'($urandom_range(21'h036F, 21'h0300));
            cols = 2'd0;
         end else if (r < 92) begin
            cp = cp_type'($urandom_range(21'h1FFFFF, 21'h10000));
            cols = 2'd2;
         end else if (r < 97) begin
            cp = CP_MARKER;
            marker_left = $urandom_range(5, 1);
         end else if (r < 98) begin
            cp = CP_NUL;
         end else begin
            cp = cp_type'($urandom_range(8'h7E, 8'h21));
         end
         send_char(cp, cols, i == len - 1);
      end
   endtask

   task automatic send_noise_text();
      int     len;
      int     i;
      cp_type cp;
      len = $urandom_range(30, 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(1) == 0)
            cp = cp_type'($urandom());
         else
            cp = cp_type'($urandom_range(127));
         send_char(cp, 2'($urandom_range(3)), (i == len - 1) || ($urandom_range(15) == 0));
      end
   endtask

   task automatic test_random_text(input int n_items, input int sender_idle,
                                   input int receiver_idle);
      int target;
      bit paused;
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      target = live_items + n_items;
      paused = 1'b0;
      while (live_items < target) begin
         if ($urandom_range(99) < 85)
            send_random_text();
         else
            send_noise_text();
         // pause once mid-phase until the block has emptied
         if (!paused && live_items >= target - n_items / 2) begin
            drain_spans();
            paused = 1'b1;
         end
      end
      drain_spans();
   endtask

   task automatic test_reset_width();
      check_line_width(LINE_WIDTH_RESET);
      test_random_text(40, 16, 84);
   endtask

   task automatic test_directed_cases();
      send_idle_pct = 16;
      recv_idle_pct = 84;
      set_line_width(32'd3);
      // cut at a space, then mid-word cuts, then a newline that ends the text
      send_char(letter("a"), 2'd1, 1'b0);
      send_char(CP_SPACE, 2'd1, 1'b0);
      send_char(letter("b"), 2'd1, 1'b0);
      send_char(letter("c"), 2'd2, 1'b0);
      send_char(letter("x"), 2'd1, 1'b0);
      send_char(21'h1FFFFF, 2'd3, 1'b0);
      send_char(21'h000301, 2'd0, 1'b0);
      send_char(CP_NEWLINE, 2'd0, 1'b1);
      // a marker closed by each closer; inside one, newline, space and NUL are plain
      send_char(CP_MARKER, 2'd1, 1'b0);
      send_char(CP_U, 2'd1, 1'b0);
      send_char(CP_MARKER, 2'd1, 1'b0);
      send_char(CP_A, 2'd2, 1'b0);
      send_char(CP_MARKER, 2'd1, 1'b0);
      send_char(CP_I, 2'd1, 1'b0);
      send_char(CP_MARKER, 2'd1, 1'b0);
      send_char(CP_B, 2'd1, 1'b0);
      send_char(CP_MARKER, 2'd1, 1'b0);
      send_char(CP_O, 2'd1, 1'b0);
      send_char(CP_MARKER, 2'd0, 1'b0);
      send_char(CP_NEWLINE, 2'd2, 1'b0);
      send_char(CP_SPACE, 2'd1, 1'b0);
      send_char(CP_NUL, 2'd1, 1'b0);
      send_char(CP_BRACE, 2'd1, 1'b0);
      // early end: ignore the rest until the last flag, then a NUL that is last
      send_char(letter("q"), 2'd1, 1'b0);
      send_char(CP_NUL, 2'd0, 1'b0);
      send_char(letter("r"), 2'd1, 1'b0);
      send_char(letter("s"), 2'd1, 1'b1);
      send_char(CP_NUL, 2'd3, 1'b1);
      // marker still open on the last word
      send_char(CP_MARKER, 2'd2, 1'b1);
      drain_spans();
   endtask

   // Freeze the receiver while words keep coming so the span queue fills.
   task automatic test_receiver_hold();
      int i;
      set_line_width(32'd12);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(negedge clock);
      hold_request = 400;
      @(posedge clock);
      for (i = 0; i < 120; i++)
         send_char(($urandom_range(1) == 0) ? CP_NEWLINE : letter("w"), 2'd1,
                   $urandom_range(19) == 0);
      drain_spans();
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_spans
      span_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_spans.size() == 0) begin
            report_mismatch("span with none pending, line_start", int'(rsp_line_start), 0);
         end else begin
            want = expected_spans.pop_front();
            if (rsp_line_start !== want.line_start)
               report_mismatch("line_start", int'(rsp_line_start), int'(want.line_start));
            if (rsp_line_end !== want.line_end)
               report_mismatch("line_end", int'(rsp_line_end), int'(want.line_end));
            if (rsp_text_done !== want.text_done)
               report_mismatch("text_done", int'(rsp_text_done), int'(want.text_done));
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", int'(rsp_run_last), int'(want.run_last));
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_width();
      test_directed_cases();
      set_line_width(32'd20);
      test_random_text(170, 16, 84);
      set_line_width(32'hFFFF_FFFF);
      test_random_text(170, 84, 16);
      set_line_width(32'd1);
      test_random_text(170, 0, 0);
      set_line_width(32'd0);
      test_random_text(40, 0, 0);
      test_receiver_hold();
      drain_spans();
      if (error_count == 0 && expected_spans.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
